FILE: design/cog_pkg.sv
// ---------------------------------------------------------------------------
// cog_pkg: shared definitions for the circle octant point generator
// Widths, command codes, decision constants, the controller/datapath
// command and status structs, and the octant point mapping.
// ---------------------------------------------------------------------------
package cog_pkg;

   // Default widths of the coordinate and radius fields.
   localparam int COORD_BITS_DEF  = 12;
   localparam int RADIUS_BITS_DEF = 11;

   // Width of the midpoint decision value.
   localparam int DEC_BITS = 16;

   // Request command codes.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Decision constants: d0 = 3 - 2r, d += 4x + 6, or d += 4(x - y) + 10.
   localparam int DEC_INIT     = 3;
   localparam int DEC_INC_AXIS = 6;
   localparam int DEC_INC_DIAG = 10;

   // Eight symmetric points are produced for every step.
   localparam int NUM_POINTS = 8;
   localparam int SEL_BITS   = $clog2(NUM_POINTS);
   localparam logic [SEL_BITS-1:0] SEL_FIRST = '0;
   localparam logic [SEL_BITS-1:0] SEL_LAST  = SEL_BITS'(NUM_POINTS - 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                start;       // Load centre, offsets and decision.
      logic                step;        // Apply one midpoint update.
      logic                emit_point;  // Register one octant point.
      logic                emit_done;   // Register the done-only result.
      logic                finish;      // Clear the running flag.
      logic [SEL_BITS-1:0] sel;         // Which of the eight points.
   } cog_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic running;   // A circle is loaded and not yet finished.
      logic past_end;  // The x offset has passed the y offset.
   } cog_status_type;

   // How one octant point is formed from the offsets.
   typedef struct packed {
      logic swap;   // Column takes y and row takes x.
      logic neg_h;  // Column offset is subtracted.
      logic neg_v;  // Row offset is subtracted.
   } cog_map_type;

   // Point order: (+x,-y) (+y,+x) (+x,+y) (-y,+x) (-y,-x) (-x,-y) (-x,+y) (+y,-x).
   function automatic cog_map_type point_map(input logic [SEL_BITS-1:0] sel);
      cog_map_type m;
      case (sel)
         3'd0:    m = '{swap: 1'b0, neg_h: 1'b0, neg_v: 1'b1};
         3'd1:    m = '{swap: 1'b1, neg_h: 1'b0, neg_v: 1'b0};
         3'd2:    m = '{swap: 1'b0, neg_h: 1'b0, neg_v: 1'b0};
         3'd3:    m = '{swap: 1'b1, neg_h: 1'b1, neg_v: 1'b0};
         3'd4:    m = '{swap: 1'b1, neg_h: 1'b1, neg_v: 1'b1};
         3'd5:    m = '{swap: 1'b0, neg_h: 1'b1, neg_v: 1'b1};
         3'd6:    m = '{swap: 1'b0, neg_h: 1'b1, neg_v: 1'b0};
         default: m = '{swap: 1'b1, neg_h: 1'b0, neg_v: 1'b1};
      endcase
      return m;
   endfunction

endpackage

FILE: design/cog_ifs.sv
// ---------------------------------------------------------------------------
// cog_req_if / cog_rsp_if: request and response channels
// Valid/ready channels; a transfer happens on a rising clock edge where
// valid and ready are both high.
// ---------------------------------------------------------------------------
interface cog_req_if #(
   parameter int COORD_BITS  = cog_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = cog_pkg::RADIUS_BITS_DEF
);
   import cog_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0] radius;

   modport source (output valid, output command, output center_x, output center_y,
                   output radius, input ready);
   modport sink   (input valid, input command, input center_x, input center_y,
                   input radius, output ready);
endinterface

interface cog_rsp_if #(
   parameter int COORD_BITS = cog_pkg::COORD_BITS_DEF
);
   import cog_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [COORD_BITS+1:0] point_x;
   logic signed [COORD_BITS+1:0] point_y;
   logic                        point_valid;
   logic                        last;
   logic                        done_res;

   modport source (output valid, output point_x, output point_y, output point_valid,
                   output last, output done_res, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_valid,
                   input last, input done_res, output ready);
endinterface

FILE: design/cog_datapath.sv
// ---------------------------------------------------------------------------
// cog_datapath: circle state, midpoint update and point output register
// Holds the centre, the two offsets and the decision value, applies one
// midpoint update per step, and forms one octant point per command.
// ---------------------------------------------------------------------------
module cog_datapath #(
   parameter int COORD_BITS  = cog_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = cog_pkg::RADIUS_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cog_pkg::cog_cmd_type         cmd,
   output cog_pkg::cog_status_type      status,
   input  logic [COORD_BITS-1:0]        center_x,
   input  logic [COORD_BITS-1:0]        center_y,
   input  logic [RADIUS_BITS-1:0]       radius,
   output logic signed [COORD_BITS+1:0] point_x,
   output logic signed [COORD_BITS+1:0] point_y,
   output logic                         point_valid,
   output logic                         last,
   output logic                         done_res
);
   import cog_pkg::*;

   localparam int OUT_BITS = COORD_BITS + 2;

   // Circle state.
   logic        [COORD_BITS-1:0] cx_ff, cx_in;
   logic        [COORD_BITS-1:0] cy_ff, cy_in;
   logic signed [COORD_BITS-1:0] a_ff, a_in;
   logic signed [COORD_BITS-1:0] b_ff, b_in;
   logic signed [DEC_BITS-1:0]   d_ff, d_in;
   logic                         running_ff, running_in;

   // Output register.
   logic signed [OUT_BITS-1:0] px_ff, px_in;
   logic signed [OUT_BITS-1:0] py_ff, py_in;
   logic                       pv_ff, pv_in;
   logic                       last_ff, last_in;
   logic                       done_ff, done_in;

   logic signed [DEC_BITS-1:0] a_ext;
   logic signed [DEC_BITS-1:0] b_ext;
   logic signed [DEC_BITS-1:0] d_start;
   logic signed [DEC_BITS-1:0] d_axis;
   logic signed [DEC_BITS-1:0] d_diag;
   cog_map_type                map;
   logic signed [OUT_BITS-1:0] cx_ext, cy_ext;
   logic signed [OUT_BITS-1:0] off_h, off_v;
   logic signed [OUT_BITS-1:0] pt_x, pt_y;

   // Decision arithmetic wraps to the decision width.
   assign a_ext   = DEC_BITS'(a_ff);
   assign b_ext   = DEC_BITS'(b_ff);
   assign d_start = DEC_BITS'(DEC_INIT) - (DEC_BITS'(radius) << 1);
   assign d_axis  = d_ff + (a_ext <<< 2) + DEC_BITS'(DEC_INC_AXIS);
   assign d_diag  = d_ff + ((a_ext - b_ext) <<< 2) + DEC_BITS'(DEC_INC_DIAG);

   // Octant point for the selected slot, wrapping to the output width.
   assign map    = point_map(cmd.sel);
   assign cx_ext = OUT_BITS'(cx_ff);
   assign cy_ext = OUT_BITS'(cy_ff);
   assign off_h  = map.swap ? OUT_BITS'(b_ff) : OUT_BITS'(a_ff);
   assign off_v  = map.swap ? OUT_BITS'(a_ff) : OUT_BITS'(b_ff);
   assign pt_x   = map.neg_h ? (cx_ext - off_h) : (cx_ext + off_h);
   assign pt_y   = map.neg_v ? (cy_ext - off_v) : (cy_ext + off_v);

   // Next state of the circle registers.
   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      d_in       = d_ff;
      running_in = running_ff;
      if (cmd.start) begin
         cx_in      = center_x;
         cy_in      = center_y;
         a_in       = '0;
         b_in       = COORD_BITS'(radius);
         d_in       = d_start;
         running_in = 1'b1;
      end else if (cmd.step) begin
         a_in = a_ff + COORD_BITS'(1);
         if (d_ff < 0) begin
            d_in = d_axis;
         end else begin
            d_in = d_diag;
            b_in = b_ff - COORD_BITS'(1);
         end
      end else if (cmd.finish) begin
         running_in = 1'b0;
      end
   end

   // Next value of the output register.
   always_comb begin
      px_in   = px_ff;
      py_in   = py_ff;
      pv_in   = pv_ff;
      last_in = last_ff;
      done_in = done_ff;
      if (cmd.emit_point) begin
         px_in   = pt_x;
         py_in   = pt_y;
         pv_in   = 1'b1;
         last_in = (cmd.sel == SEL_LAST);
         done_in = status.past_end;
      end else if (cmd.emit_done) begin
         px_in   = '0;
         py_in   = '0;
         pv_in   = 1'b0;
         last_in = 1'b1;
         done_in = 1'b1;
      end
   end

   // Circle state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff      <= '0;
         cy_ff      <= '0;
         a_ff       <= '0;
         b_ff       <= '0;
         d_ff       <= '0;
         running_ff <= 1'b0;
      end else begin
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         a_ff       <= a_in;
         b_ff       <= b_in;
         d_ff       <= d_in;
         running_ff <= running_in;
      end
   end

   // Output payload register; validity lives in the controller.
   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      pv_ff   <= pv_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign status.running  = running_ff;
   assign status.past_end = (a_ff > b_ff);

   assign point_x     = px_ff;
   assign point_y     = py_ff;
   assign point_valid = pv_ff;
   assign last        = last_ff;
   assign done_res    = done_ff;

endmodule

FILE: design/cog_controller.sv
// ---------------------------------------------------------------------------
// cog_controller: request handling and point sequencing
// Accepts requests, decides between start, step and done, and walks the
// eight point slots into the output register, one per free cycle.
// ---------------------------------------------------------------------------
module cog_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_command,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  cog_pkg::cog_status_type status,
   output cog_pkg::cog_cmd_type    cmd
);
   import cog_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                state_ff, state_in;
   logic [SEL_BITS-1:0] sel_ff, sel_in;
   logic                valid_ff, valid_in;

   logic out_free;
   logic req_xfer;
   logic step_xfer;
   logic done_case;

   // The output register can load when empty or being drained.
   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign step_xfer = req_xfer && (req_command == CMD_STEP);
   assign done_case = step_xfer && (!status.running || status.past_end);

   // Datapath commands.
   assign cmd.start      = req_xfer && (req_command == CMD_START);
   assign cmd.step       = step_xfer && !done_case;
   assign cmd.emit_done  = done_case;
   assign cmd.finish     = done_case;
   assign cmd.emit_point = (state_ff == ST_EMIT) && out_free;
   assign cmd.sel        = sel_ff;

   // State, slot counter and output valid.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.step) begin
               state_in = ST_EMIT;
               sel_in   = SEL_FIRST;
            end
         end
         ST_EMIT: begin
            if (cmd.emit_point) begin
               sel_in = sel_ff + SEL_BITS'(1);
               if (sel_ff == SEL_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.emit_point || cmd.emit_done) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_FIRST;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   // A point and a done result are never loaded in the same cycle.
   a_emit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_point && cmd.emit_done))
      else $error("point and done result loaded together");

   // No request is taken while points of a step are still being sent.
   a_no_accept_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !req_ready)
      else $error("request accepted during point sequence");

   // A step always starts its sequence at the first slot.
   a_step_starts_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (state_ff == ST_EMIT) && (sel_ff == SEL_FIRST))
      else $error("step did not start the point sequence");

   // Slots advance by one per loaded point.
   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_point && (sel_ff != SEL_LAST)) |=>
         (state_ff == ST_EMIT) && (sel_ff == $past(sel_ff) + SEL_BITS'(1)))
      else $error("point slot skipped or repeated");

endmodule

FILE: design/circle_octant_point_generator_top.sv
// ---------------------------------------------------------------------------
// circle_octant_point_generator_top: midpoint circle point generator
// Draws a circle one octant step at a time and streams the eight symmetric
// pixels of each step on the response channel.
// ---------------------------------------------------------------------------
// A start request (command 0) loads centre and radius and gives no response.
// A step request (command 1) is taken when the block is idle and its output
// register is free; it updates the offsets in that cycle and then sends eight
// points, one per cycle while rsp ready is high, the eighth marked last. All
// eight points pass through the single output register fed by one column and
// one row adder. A step after the circle has finished, or before any start,
// gives one done-only response instead.
module circle_octant_point_generator_top #(
   parameter int COORD_BITS  = cog_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = cog_pkg::RADIUS_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   cog_req_if.sink   req_ch,
   cog_rsp_if.source rsp_ch
);
   import cog_pkg::*;

   cog_cmd_type    cmd;
   cog_status_type status;

   // Sequencing of requests and results.
   cog_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // Circle state, arithmetic and output payload.
   cog_datapath #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .center_x    (req_ch.center_x),
      .center_y    (req_ch.center_y),
      .radius      (req_ch.radius),
      .point_x     (rsp_ch.point_x),
      .point_y     (rsp_ch.point_y),
      .point_valid (rsp_ch.point_valid),
      .last        (rsp_ch.last),
      .done_res    (rsp_ch.done_res)
   );

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for the circle octant point generator
// A queue of start and step commands feeds a request driver that idles at
// random. A predictor of the midpoint circle walk computes the eight
// octant pixels, or the done-only result, of each accepted command. A
// response monitor, which also stalls at random, checks every pixel field by
// field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
   import cog_pkg::*;

   localparam int CW            = COORD_BITS_DEF;
   localparam int RW            = RADIUS_BITS_DEF;
   localparam int PW            = CW + 2;
   localparam int NUM_CMDS      = 260;
   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_LIMIT   = 1000;

   // One request command as queued for the driver.
   typedef struct {
      logic          command;
      logic [CW-1:0] center_x;
      logic [CW-1:0] center_y;
      logic [RW-1:0] radius;
      bit            drain_first;  // Hold this command until all pixels are out.
   } circle_cmd_type;

   // One response as the block should produce it.
   typedef struct {
      logic signed [PW-1:0] point_x;
      logic signed [PW-1:0] point_y;
      logic                 point_valid;
      logic                 last;
      logic                 done_res;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cog_req_if req_if ();
   cog_rsp_if rsp_if ();

   circle_octant_point_generator_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   circle_cmd_type pending_cmds[$];
   pixel_type      expected_pixels[$];

   int total_cmds    = 0;
   int accepted_cmds = 0;
   int pixel_count   = 0;
   int fail_count    = 0;
   int stall_cycles  = 0;
   int send_gap      = 0;
   int ready_hold    = 0;
   bit req_taken     = 1'b0;
   bit rsp_taken     = 1'b0;

   // Predictor state: centre, offsets, decision value and the running flag.
   logic [CW-1:0]              ctr_col;
   logic [CW-1:0]              ctr_row;
   logic signed [CW-1:0]       off_x;
   logic signed [CW-1:0]       off_y;
   logic signed [DEC_BITS-1:0] dec_val;
   bit                         circle_active;

   // Clock with a period of 4 time units.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle cycles before the next transfer; some stretches run without any.
   function automatic int pick_idle(input int count);
      if ((count / 30) % 3 == 1)
         return 0;
      return $urandom_range(0, 10);
   endfunction

   task automatic add_cmd(input logic command, input int cx, input int cy, input int rad,
                          input bit drain);
      circle_cmd_type c;
      c.command     = command;
      c.center_x    = CW'(cx);
      c.center_y    = CW'(cy);
      c.radius      = RW'(rad);
      c.drain_first = drain;
      pending_cmds.push_back(c);
      total_cmds++;
   endtask

   // Advance the circle walk by one command and queue the pixels it yields.
   task automatic predict_circle(input circle_cmd_type c);
      int        x;
      int        y;
      int        d;
      int        cx;
      int        cy;
      int        col[NUM_POINTS];
      int        row[NUM_POINTS];
      pixel_type p;
      if (c.command == CMD_START) begin
         ctr_col       = c.center_x;
         ctr_row       = c.center_y;
         off_x         = '0;
         off_y         = CW'(c.radius);
         dec_val       = DEC_BITS'(DEC_INIT - 2 * int'(c.radius));
         circle_active = 1'b1;
         return;
      end
      // A step before any start or past the end of the circle only reports done.
      if (!circle_active || off_x > off_y) begin
         circle_active = 1'b0;
         p = '{point_x: '0, point_y: '0, point_valid: 1'b0, last: 1'b1, done_res: 1'b1};
         expected_pixels.push_back(p);
         return;
      end
      x = off_x;
      y = off_y;
      d = dec_val;
      if (d < 0) begin
         d = d + 4 * x + DEC_INC_AXIS;
         x = x + 1;
      end else begin
         d = d + 4 * (x - y) + DEC_INC_DIAG;
         x = x + 1;
         y = y - 1;
      end
      off_x   = CW'(x);
      off_y   = CW'(y);
      dec_val = DEC_BITS'(d);
      x  = off_x;
      y  = off_y;
      cx = ctr_col;
      cy = ctr_row;
      col = '{cx + x, cx + y, cx + x, cx - y, cx - y, cx - x, cx - x, cx + y};
      row = '{cy - y, cy + x, cy + y, cy + x, cy - x, cy - y, cy + y, cy - x};
      for (int k = 0; k < NUM_POINTS; k++) begin
         p.point_x     = PW'(col[k]);
         p.point_y     = PW'(row[k]);
         p.point_valid = 1'b1;
         p.last        = (k == NUM_POINTS - 1);
         p.done_res    = (off_x > off_y);
         expected_pixels.push_back(p);
      end
   endtask

   // Reset sequence.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Request driver: one command per transfer, with random idle cycles before each.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.command  <= CMD_START;
         req_if.center_x <= '0;
         req_if.center_y <= '0;
         req_if.radius   <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (req_if.valid)
            send_gap = pick_idle(accepted_cmds);
         if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_cmds.size() != 0 &&
                      !(pending_cmds[0].drain_first && expected_pixels.size() != 0)) begin
            req_if.command  <= pending_cmds[0].command;
            req_if.center_x <= pending_cmds[0].center_x;
            req_if.center_y <= pending_cmds[0].center_y;
            req_if.radius   <= pending_cmds[0].radius;
            req_if.valid    <= 1'b1;
            void'(pending_cmds.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response ready: after each transfer the receiver may stall for a while.
   always @(negedge clock) begin
      if (reset) begin
         ready_hold = 0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken)
            ready_hold = pick_idle(pixel_count);
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor: check responses, predict accepted commands, watch for progress.
   always @(posedge clock) begin
      bit        rsp_xfer;
      bit        req_xfer;
      int        errs;
      pixel_type want;
      rsp_xfer = !reset && rsp_if.valid && rsp_if.ready;
      req_xfer = !reset && req_if.valid && req_if.ready;
      errs     = 0;
      if (reset) begin
         ctr_col       = '0;
         ctr_row       = '0;
         off_x         = '0;
         off_y         = '0;
         dec_val       = '0;
         circle_active = 1'b0;
      end
      if (rsp_xfer) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected response: point_x %0d, point_y %0d, last %0b",
                   rsp_if.point_x, rsp_if.point_y, rsp_if.last);
            errs++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_if.point_x !== want.point_x) begin
               $error("point_x: expected %0d, got %0d", want.point_x, rsp_if.point_x);
               errs++;
            end
            if (rsp_if.point_y !== want.point_y) begin
               $error("point_y: expected %0d, got %0d", want.point_y, rsp_if.point_y);
               errs++;
            end
            if (rsp_if.point_valid !== want.point_valid) begin
               $error("point_valid: expected %0b, got %0b", want.point_valid,
                      rsp_if.point_valid);
               errs++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_if.last);
               errs++;
            end
            if (rsp_if.done_res !== want.done_res) begin
               $error("done_res: expected %0b, got %0b", want.done_res, rsp_if.done_res);
               errs++;
            end
         end
      end
      // Responses of the same edge are checked first, since a command never
      // answers at its own transfer.
      if (req_xfer)
         predict_circle('{command: req_if.command, center_x: req_if.center_x,
                          center_y: req_if.center_y, radius: req_if.radius,
                          drain_first: 1'b0});
      fail_count    <= fail_count + errs;
      pixel_count   <= pixel_count + int'(rsp_xfer);
      accepted_cmds <= accepted_cmds + int'(req_xfer);
      stall_cycles  <= (rsp_xfer || req_xfer) ? 0 : stall_cycles + 1;
      req_taken     <= req_xfer;
      rsp_taken     <= rsp_xfer;
   end

   // Watchdog: the run is stuck when nothing transfers for too long.
   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(negedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus and end of test.
   initial begin
      int n_steps;
      int rad;
      // Directed: step before any start, zero radius, extreme centres and radius,
      // radius one, a restart in mid-circle and steps past the end.
      add_cmd(CMD_STEP, (1 << CW) - 1, 0, (1 << RW) - 1, 1'b0);
      add_cmd(CMD_START, 0, 0, 0, 1'b0);
      add_cmd(CMD_STEP, 0, 0, 0, 1'b0);
      add_cmd(CMD_STEP, 0, 0, 0, 1'b1);
      add_cmd(CMD_STEP, 0, 0, 0, 1'b0);
      add_cmd(CMD_START, (1 << CW) - 1, (1 << CW) - 1, (1 << RW) - 1, 1'b0);
      repeat (3) add_cmd(CMD_STEP, 0, 0, 0, 1'b0);
      add_cmd(CMD_START, 0, (1 << CW) - 1, (1 << RW) - 1, 1'b0);
      repeat (2) add_cmd(CMD_STEP, (1 << CW) - 1, 0, 0, 1'b0);
      add_cmd(CMD_START, 1 << (CW - 1), 1, 1, 1'b0);
      repeat (3) add_cmd(CMD_STEP, 0, 0, 0, 1'b0);
      add_cmd(CMD_START, 1000, 3000, 5, 1'b0);
      add_cmd(CMD_STEP, 0, 0, 0, 1'b0);
      add_cmd(CMD_START, (1 << CW) - 1, 0, 3, 1'b0);
      repeat (5) add_cmd(CMD_STEP, 0, 0, 0, 1'b0);

      // Random: mostly whole circles, some cut short or restarted, some stray steps.
      while (total_cmds < NUM_CMDS) begin
         if ($urandom_range(0, 9) < 8) begin
            rad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << RW) - 1)
                                              : $urandom_range(0, 24);
            add_cmd(CMD_START, $urandom_range(0, (1 << CW) - 1),
                    $urandom_range(0, (1 << CW) - 1), rad, $urandom_range(0, 5) == 0);
            n_steps = (rad > 24) ? $urandom_range(1, 8) : rad * 3 / 4 + $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
               n_steps = $urandom_range(1, n_steps);
            repeat (n_steps) add_cmd(CMD_STEP, $urandom, $urandom, $urandom, 1'b0);
         end else begin
            repeat ($urandom_range(1, 3)) add_cmd(CMD_STEP, $urandom, $urandom, $urandom, 1'b0);
         end
      end

      while (accepted_cmds < total_cmds || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
